// File: src/assert_macros.svh
// Assertion helpers used by the limiter core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

// File: src/cpcl_pkg.sv
// ----------------------------------------------------------------------------
// cpcl_pkg
// Types and constants shared by the chassis power current limiter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cpcl_pkg;

    localparam int BUDGET_W = 20;
    localparam logic [BUDGET_W-1:0] BUDGET_MAX = '1;

    localparam logic [2:0] REG_WARN_BUFFER    = 3'd0;
    localparam logic [2:0] REG_BUFFER_FLOOR   = 3'd1;
    localparam logic [2:0] REG_BUFFER_GAIN    = 3'd2;
    localparam logic [2:0] REG_POWER_GAIN     = 3'd3;
    localparam logic [2:0] REG_FALLBACK_LIMIT = 3'd4;

    localparam logic [15:0] RST_WARN_BUFFER    = 16'd6400;
    localparam logic [15:0] RST_BUFFER_FLOOR   = 16'd320;
    localparam logic [9:0]  RST_BUFFER_GAIN    = 10'd200;
    localparam logic [9:0]  RST_POWER_GAIN     = 10'd250;
    localparam logic [19:0] RST_FALLBACK_LIMIT = 20'd8000;

    typedef struct packed {
        logic [15:0] warn_buffer;
        logic [15:0] buffer_floor;
        logic [9:0]  buffer_gain;
        logic [9:0]  power_gain;
        logic [19:0] fallback_limit;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        LOAD_LIGHT,
        LOAD_RISING,
        LOAD_OVER
    } load_class_t;

endpackage

`default_nettype wire

// File: src/cpcl_front.sv
// ----------------------------------------------------------------------------
// cpcl_front
// Accepts items, classifies the load, computes the current budget through a
// pipelined divider and decides whether the currents must be scaled.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcl_front #(
    parameter int NUM_MOTORS = 4
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cpcl_pkg::cfg_t           cfg,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     link_ok,
    input  wire logic [15:0]              meas_power,
    input  wire logic [15:0]              buffer_energy,
    input  wire logic [15:0]              max_power,
    input  wire logic [16*NUM_MOTORS-1:0] current_in,
    output logic                          out_valid,
    input  wire logic                     out_full,
    output logic [21+16+$clog2(NUM_MOTORS)+17*NUM_MOTORS-1:0] out_data
);
    import cpcl_pkg::*;

    localparam int SW     = 16 + $clog2(NUM_MOTORS);
    localparam int STEPS  = BUDGET_W;
    localparam int SIDE_W = 3 + BUDGET_W + SW + 17*NUM_MOTORS;

    logic adv;

    logic [15:0]             diff_c;
    logic [25:0]             mbg_c;
    logic [25:0]             mpg_c;
    logic [25:0]             pgd_c;
    load_class_t             cls_c;
    logic [15:0]             e_c;
    logic [SW-1:0]           sum_c;
    logic [16*NUM_MOTORS-1:0] mag_c;
    logic [NUM_MOTORS-1:0]   neg_c;

    logic                    a_valid_reg;
    logic                    a_link_reg;
    logic                    a_low_reg;
    load_class_t             a_cls_reg;
    logic [25:0]             a_mbg_reg;
    logic [25:0]             a_mpg_reg;
    logic [26:0]             a_pgd2_reg;
    logic [15:0]             a_e_reg;
    logic [SW-1:0]           a_sum_reg;
    logic [16*NUM_MOTORS-1:0] a_mag_reg;
    logic [NUM_MOTORS-1:0]   a_neg_reg;

    logic [41:0]             x_c;
    logic [27:0]             nsum_c;
    logic [21:0]             nv_c;
    logic [BUDGET_W-1:0]     vsat_c;
    logic                    ovf_c;

    logic                    d_valid [0:STEPS];
    logic [15:0]             d_rem   [0:STEPS];
    logic [BUDGET_W-1:0]     d_num   [0:STEPS];
    logic [BUDGET_W-1:0]     d_q     [0:STEPS];
    logic [SIDE_W-1:0]       d_side  [0:STEPS];

    logic                    b_valid_reg;
    logic [15:0]             b_rem_reg;
    logic [BUDGET_W-1:0]     b_num_reg;
    logic [SIDE_W-1:0]       b_side_reg;

    logic [SIDE_W-1:0]       f_side_c;
    logic [BUDGET_W-1:0]     budget_c;
    logic                    f_valid_reg;
    logic [BUDGET_W-1:0]     f_budget_reg;
    logic                    f_limit_reg;
    logic [SW-1:0]           f_sum_reg;
    logic [16*NUM_MOTORS-1:0] f_mag_reg;
    logic [NUM_MOTORS-1:0]   f_neg_reg;

    assign adv      = !f_valid_reg || !out_full;
    assign in_ready = adv;

    assign diff_c = max_power - meas_power;
    assign mbg_c  = 26'(max_power) * 26'(cfg.buffer_gain);
    assign mpg_c  = 26'(max_power) * 26'(cfg.power_gain);
    assign pgd_c  = 26'(diff_c) * 26'(cfg.power_gain);
    assign e_c    = (buffer_energy > cfg.buffer_floor) ? buffer_energy : cfg.buffer_floor;

    always_comb
    begin
        if ({meas_power, 1'b0} <= {1'b0, max_power})
        begin
            cls_c = LOAD_LIGHT;
        end
        else if (meas_power < max_power)
        begin
            cls_c = LOAD_RISING;
        end
        else
        begin
            cls_c = LOAD_OVER;
        end
    end

    always_comb
    begin
        sum_c = '0;
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            neg_c[i]          = current_in[16*i+15];
            mag_c[16*i +: 16] = neg_c[i] ? (16'd0 - current_in[16*i +: 16])
                                         : current_in[16*i +: 16];
            sum_c             = sum_c + SW'(mag_c[16*i +: 16]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_link_reg <= link_ok;
            a_low_reg  <= link_ok && (buffer_energy < cfg.warn_buffer);
            a_cls_reg  <= cls_c;
            a_mbg_reg  <= mbg_c;
            a_mpg_reg  <= mpg_c;
            a_pgd2_reg <= {pgd_c, 1'b0};
            a_e_reg    <= e_c;
            a_sum_reg  <= sum_c;
            a_mag_reg  <= mag_c;
            a_neg_reg  <= neg_c;
        end
    end

    assign x_c   = 42'(a_mbg_reg) * 42'(a_e_reg);
    assign ovf_c = x_c[41:26] >= cfg.warn_buffer;

    always_comb
    begin
        case (a_cls_reg)
            LOAD_LIGHT:  nsum_c = 28'(a_mbg_reg) + 28'(a_mpg_reg);
            LOAD_RISING: nsum_c = 28'(a_mbg_reg) + 28'(a_pgd2_reg);
            default:     nsum_c = 28'(a_mbg_reg);
        endcase
    end

    assign nv_c   = nsum_c[27:6];
    assign vsat_c = (|nv_c[21:20]) ? BUDGET_MAX : nv_c[19:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_rem_reg  <= x_c[41:26];
            b_num_reg  <= x_c[25:6];
            b_side_reg <= {a_neg_reg, a_mag_reg, a_sum_reg, vsat_c, ovf_c,
                           a_low_reg, a_link_reg};
        end
    end

    assign d_valid[0] = b_valid_reg;
    assign d_rem[0]   = b_rem_reg;
    assign d_num[0]   = b_num_reg;
    assign d_q[0]     = '0;
    assign d_side[0]  = b_side_reg;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_div
        logic [16:0]         t_c;
        logic                ge_c;
        logic [15:0]         rem_next;
        logic                valid_reg;
        logic [15:0]         rem_reg;
        logic [BUDGET_W-1:0] num_reg;
        logic [BUDGET_W-1:0] q_reg;
        logic [SIDE_W-1:0]   side_reg;

        assign t_c      = {d_rem[k], d_num[k][BUDGET_W-1]};
        assign ge_c     = t_c >= {1'b0, cfg.warn_buffer};
        assign rem_next = ge_c ? 16'(t_c - {1'b0, cfg.warn_buffer}) : t_c[15:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg <= d_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg  <= rem_next;
                num_reg  <= {d_num[k][BUDGET_W-2:0], 1'b0};
                q_reg    <= {d_q[k][BUDGET_W-2:0], ge_c};
                side_reg <= d_side[k];
            end
        end

        assign d_valid[k+1] = valid_reg;
        assign d_rem[k+1]   = rem_reg;
        assign d_num[k+1]   = num_reg;
        assign d_q[k+1]     = q_reg;
        assign d_side[k+1]  = side_reg;
    end

    assign f_side_c = d_side[STEPS];

    always_comb
    begin
        if (!f_side_c[0])
        begin
            budget_c = cfg.fallback_limit;
        end
        else if (f_side_c[1])
        begin
            budget_c = f_side_c[2] ? BUDGET_MAX : d_q[STEPS];
        end
        else
        begin
            budget_c = f_side_c[3 +: BUDGET_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg <= d_valid[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_budget_reg <= budget_c;
            f_limit_reg  <= (SW + BUDGET_W)'(f_side_c[3+BUDGET_W +: SW]) >
                            (SW + BUDGET_W)'(budget_c);
            f_sum_reg    <= f_side_c[3+BUDGET_W +: SW];
            f_mag_reg    <= f_side_c[3+BUDGET_W+SW +: 16*NUM_MOTORS];
            f_neg_reg    <= f_side_c[3+BUDGET_W+SW+16*NUM_MOTORS +: NUM_MOTORS];
        end
    end

    assign out_valid = f_valid_reg;
    assign out_data  = {f_neg_reg, f_mag_reg, f_sum_reg, f_limit_reg, f_budget_reg};

endmodule

`default_nettype wire

// File: src/cpcl_queue.sv
// ----------------------------------------------------------------------------
// cpcl_queue
// Small first-in first-out queue between the budget front and the scaler.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire logic [WIDTH-1:0]      push_data,
    input  wire logic                  pop,
    output logic [WIDTH-1:0]           pop_data,
    output cpcl_pkg::queue_status_t    status
);
    import cpcl_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign status.full  = count_reg == CW'(DEPTH);
    assign status.empty = count_reg == '0;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: src/cpcl_back.sv
// ----------------------------------------------------------------------------
// cpcl_back
// Scales each motor current by budget over sum through pipelined dividers
// when limited and holds the result beat in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcl_back #(
    parameter int NUM_MOTORS = 4
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [21+16+$clog2(NUM_MOTORS)+17*NUM_MOTORS-1:0] in_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [16*NUM_MOTORS-1:0]      current_out,
    output logic                          was_limited,
    output logic [19:0]                   current_budget
);
    import cpcl_pkg::*;

    localparam int SW     = 16 + $clog2(NUM_MOTORS);
    localparam int STEPS  = 16;
    localparam int SIDE_W = 1 + BUDGET_W + SW + 17*NUM_MOTORS;

    logic adv;

    logic                       m_valid_reg;
    logic [SIDE_W-1:0]          m_side_reg;
    logic [36*NUM_MOTORS-1:0]   m_num_reg;
    logic [36*NUM_MOTORS-1:0]   num_c;

    logic                       d_valid [0:STEPS];
    logic [SW*NUM_MOTORS-1:0]   d_rem   [0:STEPS];
    logic [16*NUM_MOTORS-1:0]   d_num   [0:STEPS];
    logic [16*NUM_MOTORS-1:0]   d_q     [0:STEPS];
    logic [SIDE_W-1:0]          d_side  [0:STEPS];

    logic [SIDE_W-1:0]          l_side_c;
    logic [SW-1:0]              l_sum_c;
    logic [16*NUM_MOTORS-1:0]   res_c;

    logic                       o_valid_reg;
    logic [16*NUM_MOTORS-1:0]   o_cur_reg;
    logic                       o_limit_reg;
    logic [BUDGET_W-1:0]        o_budget_reg;

    assign adv      = !o_valid_reg || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            num_c[36*i +: 36] = 36'(in_data[21+SW+16*i +: 16]) * 36'(in_data[19:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_side_reg <= in_data;
            m_num_reg  <= num_c;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            d_rem[0][SW*i +: SW] = SW'(m_num_reg[36*i+16 +: 20]);
            d_num[0][16*i +: 16] = m_num_reg[36*i +: 16];
        end
    end

    assign d_valid[0] = m_valid_reg;
    assign d_q[0]     = '0;
    assign d_side[0]  = m_side_reg;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_div
        logic [SW-1:0]            sum_c;
        logic [SW*NUM_MOTORS-1:0] rem_next;
        logic [16*NUM_MOTORS-1:0] num_next;
        logic [16*NUM_MOTORS-1:0] q_next;
        logic [SW:0]              t_c [NUM_MOTORS];
        logic                     valid_reg;
        logic [SW*NUM_MOTORS-1:0] rem_reg;
        logic [16*NUM_MOTORS-1:0] num_reg;
        logic [16*NUM_MOTORS-1:0] q_reg;
        logic [SIDE_W-1:0]        side_reg;

        assign sum_c = d_side[k][1+BUDGET_W +: SW];

        always_comb
        begin
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                t_c[i] = {d_rem[k][SW*i +: SW], d_num[k][16*i+15]};
                if (t_c[i] >= {1'b0, sum_c})
                begin
                    rem_next[SW*i +: SW] = SW'(t_c[i] - {1'b0, sum_c});
                    q_next[16*i +: 16]   = {d_q[k][16*i +: 15], 1'b1};
                end
                else
                begin
                    rem_next[SW*i +: SW] = t_c[i][SW-1:0];
                    q_next[16*i +: 16]   = {d_q[k][16*i +: 15], 1'b0};
                end
                num_next[16*i +: 16] = {d_num[k][16*i +: 15], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg <= d_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg  <= rem_next;
                num_reg  <= num_next;
                q_reg    <= q_next;
                side_reg <= d_side[k];
            end
        end

        assign d_valid[k+1] = valid_reg;
        assign d_rem[k+1]   = rem_reg;
        assign d_num[k+1]   = num_reg;
        assign d_q[k+1]     = q_reg;
        assign d_side[k+1]  = side_reg;
    end

    assign l_side_c = d_side[STEPS];
    assign l_sum_c  = l_side_c[1+BUDGET_W +: SW];

    always_comb
    begin
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            logic [15:0] mag;
            mag = l_side_c[BUDGET_W] ? d_q[STEPS][16*i +: 16]
                                     : l_side_c[1+BUDGET_W+SW+16*i +: 16];
            res_c[16*i +: 16] = l_side_c[1+BUDGET_W+SW+16*NUM_MOTORS+i] ? (16'd0 - mag)
                                                                        : mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            o_valid_reg <= d_valid[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_cur_reg    <= res_c;
            o_limit_reg  <= l_side_c[BUDGET_W] && (l_sum_c != '0);
            o_budget_reg <= l_side_c[BUDGET_W-1:0];
        end
    end

    assign out_valid      = o_valid_reg;
    assign current_out    = o_cur_reg;
    assign was_limited    = o_limit_reg;
    assign current_budget = o_budget_reg;

endmodule

`default_nettype wire

// File: src/chassis_power_current_limiter_core.sv
// An accepted input beat passes the budget front pipeline, the queue and the
// scaler pipeline before its result beat leaves the output register.
// Throughput: one beat per cycle without stalls; the restoring dividers in
// the front and the scaler are fully pipelined, one quotient bit per stage.
// Reset clears all valid flags and the queue and loads the register defaults.
// ----------------------------------------------------------------------------
// chassis_power_current_limiter_core
// Computes a current budget from power and buffer data and scales the motor
// currents down when their absolute sum exceeds it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module chassis_power_current_limiter_core #(
    parameter int NUM_MOTORS = 4
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // meas_power, buffer_energy, max_power, current_in_0 .. current_in_N-1
    input  wire logic [48+16*NUM_MOTORS-1:0] s_tdata,
    // link_ok
    input  wire logic                        s_tuser,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // current_out_0 .. current_out_N-1, current_budget, zero padding
    output logic [16*NUM_MOTORS+24-1:0]      m_tdata,
    // was_limited
    output logic                             m_tuser,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [4:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import cpcl_pkg::*;

    localparam int SW = 16 + $clog2(NUM_MOTORS);
    localparam int QW = 21 + SW + 17*NUM_MOTORS;

    cfg_t              cfg_reg;
    logic              wr_en;
    logic [2:0]        reg_idx;
    logic              f_valid;
    logic [QW-1:0]     f_data;
    logic [QW-1:0]     q_data;
    queue_status_t     q_stat;
    logic              b_ready;
    logic [16*NUM_MOTORS-1:0] cur_out;
    logic [19:0]       budget_out;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.warn_buffer    <= RST_WARN_BUFFER;
            cfg_reg.buffer_floor   <= RST_BUFFER_FLOOR;
            cfg_reg.buffer_gain    <= RST_BUFFER_GAIN;
            cfg_reg.power_gain     <= RST_POWER_GAIN;
            cfg_reg.fallback_limit <= RST_FALLBACK_LIMIT;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_WARN_BUFFER:    cfg_reg.warn_buffer    <= pwdata[15:0];
                REG_BUFFER_FLOOR:   cfg_reg.buffer_floor   <= pwdata[15:0];
                REG_BUFFER_GAIN:    cfg_reg.buffer_gain    <= pwdata[9:0];
                REG_POWER_GAIN:     cfg_reg.power_gain     <= pwdata[9:0];
                REG_FALLBACK_LIMIT: cfg_reg.fallback_limit <= pwdata[19:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WARN_BUFFER:    prdata = 32'(cfg_reg.warn_buffer);
            REG_BUFFER_FLOOR:   prdata = 32'(cfg_reg.buffer_floor);
            REG_BUFFER_GAIN:    prdata = 32'(cfg_reg.buffer_gain);
            REG_POWER_GAIN:     prdata = 32'(cfg_reg.power_gain);
            REG_FALLBACK_LIMIT: prdata = 32'(cfg_reg.fallback_limit);
            default:            prdata = '0;
        endcase
    end

    cpcl_front #(
        .NUM_MOTORS(NUM_MOTORS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .link_ok       (s_tuser),
        .meas_power    (s_tdata[15:0]),
        .buffer_energy (s_tdata[31:16]),
        .max_power     (s_tdata[47:32]),
        .current_in    (s_tdata[48 +: 16*NUM_MOTORS]),
        .out_valid     (f_valid),
        .out_full      (q_stat.full),
        .out_data      (f_data)
    );

    cpcl_queue #(
        .WIDTH(QW),
        .DEPTH(4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .push_data (f_data),
        .pop       (b_ready),
        .pop_data  (q_data),
        .status    (q_stat)
    );

    cpcl_back #(
        .NUM_MOTORS(NUM_MOTORS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (!q_stat.empty),
        .in_ready       (b_ready),
        .in_data        (q_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .current_out    (cur_out),
        .was_limited    (m_tuser),
        .current_budget (budget_out)
    );

    assign m_tdata = {4'b0, budget_out, cur_out};

    `ASSERT_ALWAYS(a_queue_state, clk, rst_n, !(q_stat.full && q_stat.empty),
        "queue reports full and empty at once")
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, !s_tready, q_stat.full && f_valid,
        "front stalled without a full queue")

endmodule

`default_nettype wire
